// File: hdl/wmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmt_pkg
// Shared types, constants and arithmetic helpers of the minimap transform.
// ----------------------------------------------------------------------------
package wmt_pkg;

	localparam int ANGLE_BITS_DEF  = 16;
	localparam int FRAC_BITS_DEF   = 4;
	localparam int EDGE_MARGIN_DEF = 5;

	localparam int FIFO_DEPTH = 64;
	localparam int OUT_W      = 32;

	localparam logic [10:0] DISPLAY_SIZE_RST = 11'd256;
	localparam logic [15:0] WORLD_RANGE_RST  = 16'd1000;
	localparam logic [10:0] DISPLAY_SIZE_MAX = 11'd1024;

	typedef enum logic {
		REG_DISPLAY_SIZE = 1'b0,
		REG_WORLD_RANGE  = 1'b1
	} reg_idx_t;

	// Q30 constants
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'h6487_ED51;

	localparam longint unsigned P40 = 64'd1 << 40;

	// ceil(2^40 / den): exact floor division for 32-bit numerators
	localparam logic [39:0] SIN_RCP [7] = '{
		40'((P40 + 64'd209) / 64'd210),
		40'((P40 + 64'd155) / 64'd156),
		40'((P40 + 64'd109) / 64'd110),
		40'((P40 + 64'd71)  / 64'd72),
		40'((P40 + 64'd41)  / 64'd42),
		40'((P40 + 64'd19)  / 64'd20),
		40'((P40 + 64'd5)   / 64'd6)
	};
	localparam logic [39:0] COS_RCP [7] = '{
		40'((P40 + 64'd181) / 64'd182),
		40'((P40 + 64'd131) / 64'd132),
		40'((P40 + 64'd89)  / 64'd90),
		40'((P40 + 64'd55)  / 64'd56),
		40'((P40 + 64'd29)  / 64'd30),
		40'((P40 + 64'd11)  / 64'd12),
		40'((P40 + 64'd1)   / 64'd2)
	};

	typedef struct packed {
		logic [9:0]  half;
		logic [15:0] rng;
	} wmt_cfg_t;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dz;
		logic [1:0]         quad;
		logic [30:0]        x;
		logic [31:0]        x2;
	} wmt_carry_t;

	// (a * b) >> 30 for a Q30 square times a Q30 term
	function automatic logic [31:0] mul_q30(logic [31:0] a, logic [30:0] b);
		logic [62:0] pr;
		pr = 63'(a) * 63'(b);
		mul_q30 = pr[61:30];
	endfunction

	// t = clamp(1 - p / den, 0, 1)
	function automatic logic [30:0] horner_step(logic [31:0] p, logic [39:0] rcp);
		logic [71:0] prod;
		logic [31:0] d;
		prod = 72'(p) * 72'(rcp);
		d = prod[71:40];
		horner_step = (d >= 32'(ONE_Q30)) ? 31'd0 : 31'(32'(ONE_Q30) - d);
	endfunction

endpackage

// File: hdl/wmt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmt_core
// Free-running transform pipeline: offset, sin/cos series, rotation, scale,
// restoring division and clamp. One item per cycle, no back-pressure.
// ----------------------------------------------------------------------------
module wmt_core #(
	parameter int ANGLE_BITS  = wmt_pkg::ANGLE_BITS_DEF,
	parameter int FRAC_BITS   = wmt_pkg::FRAC_BITS_DEF,
	parameter int EDGE_MARGIN = wmt_pkg::EDGE_MARGIN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wmt_pkg::wmt_cfg_t      cfg,
	input  logic                   in_v,
	input  logic signed [31:0]     target_x,
	input  logic signed [31:0]     target_z,
	input  logic signed [31:0]     viewer_x,
	input  logic signed [31:0]     viewer_z,
	input  logic [ANGLE_BITS-1:0]  heading,
	output logic                   out_v,
	output logic signed [13:0]     map_x,
	output logic signed [13:0]     map_z
);
	import wmt_pkg::*;

	localparam int QB  = 9 + FRAC_BITS;
	localparam int XW  = 75;
	localparam int NST = 25 + QB;

	typedef struct packed {
		logic [XW-1:0] rem;
		logic [QB-1:0] q;
		logic          sat;
		logic          neg;
	} div_t;

	logic [NST:1] vld_s;

	logic signed [32:0] dx_s1, dz_s1;
	logic [1:0]         quad_s1;
	logic [29:0]        r_s1;

	logic signed [32:0] dx_s2, dz_s2;
	logic [1:0]         quad_s2;
	logic [30:0]        x_s2;

	wmt_carry_t hc_s [15];
	logic [31:0] ps_s [7];
	logic [31:0] pc_s [7];
	logic [30:0] ts_s [7];
	logic [30:0] tc_s [7];

	wmt_carry_t  hc_s18;
	logic [30:0] s_s18, c_s18;
	logic [31:0] sx_full;

	logic signed [32:0] dx_s19, dz_s19;
	logic signed [31:0] sn_s19, cs_s19;

	logic signed [64:0] pxc_s20, pzs_s20, pxs_s20, pzc_s20;

	logic signed [65:0] rot_s21 [2];

	logic [63:0]   u_s22 [2];
	logic          neg_s22 [2];
	logic [XW-1:0] x_s23 [2];
	logic          neg_s23 [2];

	div_t dv_s [2][QB+1];

	logic [9:0]        lim_px;
	logic [QB-1:0]     lim;
	logic [XW-1:0]     rng_w;
	logic signed [13:0] res_s [2];

	assign lim_px = (cfg.half > 10'(EDGE_MARGIN)) ? cfg.half - 10'(EDGE_MARGIN) : 10'd0;
	assign lim    = QB'(lim_px) << FRAC_BITS;
	assign rng_w  = XW'(cfg.rng);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NST-1:1], in_v};
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= 33'(target_x) - 33'(viewer_x);
		dz_s1   <= 33'(target_z) - 33'(viewer_z);
		quad_s1 <= heading[ANGLE_BITS-1 -: 2];
		r_s1    <= 30'(30'(heading) << (32 - ANGLE_BITS));

		dx_s2   <= dx_s1;
		dz_s2   <= dz_s1;
		quad_s2 <= quad_s1;
		x_s2    <= 31'((61'(r_s1) * 61'(HALF_PI_Q30)) >> 30);

		hc_s[0].dx   <= dx_s2;
		hc_s[0].dz   <= dz_s2;
		hc_s[0].quad <= quad_s2;
		hc_s[0].x    <= x_s2;
		hc_s[0].x2   <= mul_q30({1'b0, x_s2}, x_s2);
	end

	for (genvar j = 0; j < 7; j++) begin : g_horner
		logic [30:0] tsp, tcp;
		if (j == 0) begin : g_first
			assign tsp = ONE_Q30;
			assign tcp = ONE_Q30;
		end else begin : g_next
			assign tsp = ts_s[j-1];
			assign tcp = tc_s[j-1];
		end
		always_ff @(posedge clk) begin
			hc_s[2*j+1] <= hc_s[2*j];
			ps_s[j]     <= mul_q30(hc_s[2*j].x2, tsp);
			pc_s[j]     <= mul_q30(hc_s[2*j].x2, tcp);
			hc_s[2*j+2] <= hc_s[2*j+1];
			ts_s[j]     <= horner_step(ps_s[j], SIN_RCP[j]);
			tc_s[j]     <= horner_step(pc_s[j], COS_RCP[j]);
		end
	end

	assign sx_full = mul_q30({1'b0, hc_s[14].x}, ts_s[6]);

	always_ff @(posedge clk) begin
		hc_s18 <= hc_s[14];
		s_s18  <= (sx_full > 32'(ONE_Q30)) ? ONE_Q30 : 31'(sx_full);
		c_s18  <= tc_s[6];

		dx_s19 <= hc_s18.dx;
		dz_s19 <= hc_s18.dz;
		case (hc_s18.quad)
			2'd0: begin
				sn_s19 <= 32'(s_s18);
				cs_s19 <= 32'(c_s18);
			end
			2'd1: begin
				sn_s19 <= 32'(c_s18);
				cs_s19 <= 32'd0 - 32'(s_s18);
			end
			2'd2: begin
				sn_s19 <= 32'd0 - 32'(s_s18);
				cs_s19 <= 32'd0 - 32'(c_s18);
			end
			default: begin
				sn_s19 <= 32'd0 - 32'(c_s18);
				cs_s19 <= 32'(s_s18);
			end
		endcase

		pxc_s20 <= 65'(dx_s19) * 65'(cs_s19);
		pzs_s20 <= 65'(dz_s19) * 65'(sn_s19);
		pxs_s20 <= 65'(dx_s19) * 65'(sn_s19);
		pzc_s20 <= 65'(dz_s19) * 65'(cs_s19);

		rot_s21[0] <= 66'(pxc_s20) - 66'(pzs_s20);
		rot_s21[1] <= 66'(pxs_s20) + 66'(pzc_s20);
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [65:0] mag;
		assign mag = rot_s21[l][65] ? 66'd0 - 66'(rot_s21[l]) : 66'(rot_s21[l]);

		always_ff @(posedge clk) begin
			neg_s22[l] <= rot_s21[l][65];
			u_s22[l]   <= mag[63:0];

			neg_s23[l] <= neg_s22[l];
			x_s23[l]   <= XW'(u_s22[l]) * XW'(cfg.half) + (rng_w << 29);

			dv_s[l][0].rem <= x_s23[l];
			dv_s[l][0].q   <= '0;
			dv_s[l][0].sat <= (x_s23[l] >> (30 + QB)) >= rng_w;
			dv_s[l][0].neg <= neg_s23[l];
		end

		for (genvar d = 0; d < QB; d++) begin : g_div
			logic [XW-1:0] trial;
			div_t          nxt;
			assign trial = rng_w << (30 + QB - 1 - d);
			always_comb begin
				nxt = dv_s[l][d];
				if (dv_s[l][d].rem >= trial) begin
					nxt.rem       = dv_s[l][d].rem - trial;
					nxt.q[QB-1-d] = 1'b1;
				end
			end
			always_ff @(posedge clk) begin
				dv_s[l][d+1] <= nxt;
			end
		end

		logic [QB-1:0] m;
		logic [13:0]   m14;
		assign m   = (dv_s[l][QB].sat || dv_s[l][QB].q > lim) ? lim : dv_s[l][QB].q;
		assign m14 = 14'(m);

		always_ff @(posedge clk) begin
			res_s[l] <= dv_s[l][QB].neg ? 14'd0 - m14 : m14;
		end
	end

	assign out_v = vld_s[NST];
	assign map_x = res_s[0];
	assign map_z = res_s[1];

endmodule

// File: hdl/world_to_minimap_transform_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_minimap_transform_top
// Maps target world positions onto a viewer-centered, heading-aligned minimap.
// ----------------------------------------------------------------------------
// Input beats on s_* carry target and viewer positions plus the heading; each
// produces one output beat on m_* with the clamped minimap offsets.
// Throughput: one beat per cycle, sustained while credits remain (s_tready high).
// Path from accept to m_tvalid: a free-running core of 25 + FRAC_BITS + 9
// stages (sin/cos series in seven two-stage steps, one stage per quotient bit
// of the scale division), then a result FIFO write and the output register.
// Back-pressure: the core never stalls; results land in a 64-entry FIFO. A
// credit counter lets up to 64 beats be in flight, so s_tready stays high while
// m_tready is low until 64 results are outstanding.
// Reset: pipeline empty, FIFO empty, display_size = 256, world_range = 1000.
// Registers (cfg_idx): 0 display_size, 1 world_range; write only while idle.
// ----------------------------------------------------------------------------
module world_to_minimap_transform_top #(
	parameter int ANGLE_BITS  = wmt_pkg::ANGLE_BITS_DEF,
	parameter int FRAC_BITS   = wmt_pkg::FRAC_BITS_DEF,
	parameter int EDGE_MARGIN = wmt_pkg::EDGE_MARGIN_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// target_x, target_z, viewer_x, viewer_z, heading, zero pad
	input  logic [((128 + ANGLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// map_x, map_z, zero pad
	output logic [wmt_pkg::OUT_W-1:0]              m_tdata,
	input  logic                                    cfg_we,
	input  logic                                    cfg_idx,
	input  logic [15:0]                             cfg_data
);
	import wmt_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [10:0] dsize_q;
	logic [15:0] wrange_q;
	wmt_cfg_t    cfg;
	logic [10:0] size_eff;

	logic               core_v;
	logic signed [13:0] core_x, core_z;

	logic [27:0]   mem [FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] fcnt_q, cnt_q;
	logic          ovld_q;
	logic [27:0]   odata_q;
	logic          acc, dlv, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsize_q  <= DISPLAY_SIZE_RST;
			wrange_q <= WORLD_RANGE_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_DISPLAY_SIZE: dsize_q  <= cfg_data[10:0];
				REG_WORLD_RANGE:  wrange_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign size_eff = (dsize_q > DISPLAY_SIZE_MAX) ? DISPLAY_SIZE_MAX : dsize_q;
	assign cfg.half = size_eff[10:1];
	assign cfg.rng  = (wrange_q == 16'd0) ? 16'd1 : wrange_q;

	assign acc      = s_tvalid && s_tready;
	assign dlv      = ovld_q && m_tready;
	assign s_tready = cnt_q < CW'(FIFO_DEPTH);
	assign pop      = (fcnt_q != '0) && (!ovld_q || m_tready);

	wmt_core #(
		.ANGLE_BITS (ANGLE_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.EDGE_MARGIN(EDGE_MARGIN)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_v    (acc),
		.target_x(s_tdata[31:0]),
		.target_z(s_tdata[63:32]),
		.viewer_x(s_tdata[95:64]),
		.viewer_z(s_tdata[127:96]),
		.heading (s_tdata[128 +: ANGLE_BITS]),
		.out_v   (core_v),
		.map_x   (core_x),
		.map_z   (core_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			fcnt_q <= '0;
			wr_q   <= '0;
			rd_q   <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (acc && !dlv) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!acc && dlv) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (core_v && !pop) begin
				fcnt_q <= fcnt_q + 1'b1;
			end else if (!core_v && pop) begin
				fcnt_q <= fcnt_q - 1'b1;
			end
			if (core_v) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q   <= rd_q + 1'b1;
				ovld_q <= 1'b1;
			end else if (m_tready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (core_v) begin
			mem[wr_q] <= {core_z, core_x};
		end
		if (pop) begin
			odata_q <= mem[rd_q];
		end
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = {4'd0, odata_q};

	// credits never exceed the result FIFO
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(FIFO_DEPTH))
		else $error("in-flight count above FIFO depth");

	// a core result never meets a full FIFO
	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		core_v |-> fcnt_q < CW'(FIFO_DEPTH))
		else $error("result FIFO overflow");

	// an output beat is always backed by an accepted input
	a_out_credit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt_q != '0)
		else $error("output beat without outstanding input");

endmodule

// File: test/tb_world_to_minimap_transform_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_world_to_minimap_transform_top
// Self-checking bench for the world-to-minimap rotate/scale/clamp transform.
// ----------------------------------------------------------------------------
// Input beats are predicted in fixed point (Q30 series sin/cos, exact 64-bit
// rotation, floor scale, round half away from zero, symmetric clamp) and the
// expected offsets are queued. Each output beat is checked against the oldest
// entry. Directed corners and register extremes come first, then random beats
// under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_world_to_minimap_transform_top;
	import wmt_pkg::*;

	localparam longint unsigned Q30     = 64'd1 << 30;
	localparam longint unsigned HPI_Q30 = 64'h6487_ED51;
	localparam int              MARGIN  = 5;
	localparam int              FRACB   = 4;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// target_x, target_z, viewer_x, viewer_z, heading
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// map_x, map_z, zero pad
	logic [31:0]  m_tdata;
	logic         cfg_we;
	logic         cfg_idx;
	logic [15:0]  cfg_data;

	logic [10:0] disp_size;
	logic [15:0] wrange;
	logic [27:0] pending_maps[$];
	int          mismatches;
	int          src_idle_pct;
	int          sink_stall_pct;

	world_to_minimap_transform_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("world_to_minimap_transform_top verification failed");
		$finish;
	end

	function automatic longint unsigned series_step(longint unsigned x2, longint unsigned t,
			longint unsigned den);
		longint unsigned d;
		d = ((x2 * t) >> 30) / den;
		return (d >= Q30) ? 64'd0 : Q30 - d;
	endfunction

	function automatic logic [13:0] scale_axis(longint rot, longint unsigned half,
			longint unsigned rng, longint unsigned lim);
		logic            neg;
		longint unsigned u, q, rem, v, m;
		neg = rot < 0;
		u = neg ? 64'd0 - longint'(rot) : longint'(rot);
		q = u / rng;
		rem = u % rng;
		if (q >= (64'd1 << 53)) begin
			m = lim;
		end else begin
			v = q * half + (rem * half) / rng;
			m = (v + (64'd1 << 29)) >> 30;
			if (m > lim) m = lim;
		end
		if (neg) m = 64'd0 - m;
		return m[13:0];
	endfunction

	// returns {map_z, map_x}
	function automatic logic [27:0] predict_map(logic signed [31:0] tx, logic signed [31:0] tz,
			logic signed [31:0] vx, logic signed [31:0] vz, logic [15:0] hd);
		longint          dx, dz, sn, cs, rx, rz;
		longint unsigned sz, half, rng, lim, x, x2, ts, tc, s, c;
		logic [31:0]     a;
		dx = longint'(tx) - longint'(vx);
		dz = longint'(tz) - longint'(vz);
		sz = (disp_size > 11'd1024) ? 64'd1024 : 64'(disp_size);
		half = sz >> 1;
		rng = (wrange == 16'd0) ? 64'd1 : 64'(wrange);
		lim = ((half > MARGIN) ? half - MARGIN : 64'd0) << FRACB;
		a = {hd, 16'd0};
		x = (64'(a[29:0]) * HPI_Q30) >> 30;
		x2 = (x * x) >> 30;
		ts = Q30;
		tc = Q30;
		for (int k = 14; k >= 2; k -= 2) ts = series_step(x2, ts, k * (k + 1));
		for (int k = 13; k >= 1; k -= 2) tc = series_step(x2, tc, k * (k + 1));
		s = (x * ts) >> 30;
		if (s > Q30) s = Q30;
		c = tc;
		case (a[31:30])
			2'd0: begin sn = longint'(s);  cs = longint'(c);  end
			2'd1: begin sn = longint'(c);  cs = -longint'(s); end
			2'd2: begin sn = -longint'(s); cs = -longint'(c); end
			default: begin sn = -longint'(c); cs = longint'(s); end
		endcase
		rx = dx * cs - dz * sn;
		rz = dx * sn + dz * cs;
		return {scale_axis(rz, half, rng, lim), scale_axis(rx, half, rng, lim)};
	endfunction

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		logic [27:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_maps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: map_x=%0d map_z=%0d",
						$signed(m_tdata[13:0]), $signed(m_tdata[27:14]));
			end else begin
				want = pending_maps.pop_front();
				if (m_tdata[13:0] !== want[13:0] || m_tdata[27:14] !== want[27:14]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("map mismatch: exp x=%0d z=%0d got x=%0d z=%0d",
							$signed(want[13:0]), $signed(want[27:14]),
							$signed(m_tdata[13:0]), $signed(m_tdata[27:14]));
				end
			end
		end
	end

	task automatic send_target(logic [31:0] tx, logic [31:0] tz, logic [31:0] vx,
			logic [31:0] vz, logic [15:0] hd);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {hd, vz, vx, tz, tx};
		do @(posedge clk); while (!s_tready);
		pending_maps = {pending_maps, predict_map(tx, tz, vx, vz, hd)};
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_maps.size() == 0);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DISPLAY_SIZE) disp_size = val[10:0];
		else wrange = val;
	endtask

	task automatic send_random(int n, bit pause_often);
		int          span, off_x, off_z, mode;
		logic [31:0] vx, vz;
		logic [15:0] hd;
		for (int i = 0; i < n; i++) begin
			span = int'(wrange) * 32 + 64;
			mode = $urandom_range(9);
			vx = $urandom;
			vz = $urandom;
			hd = $urandom;
			off_x = int'($urandom_range(2 * span)) - span;
			off_z = int'($urandom_range(2 * span)) - span;
			if (mode == 8)
				send_target($urandom, $urandom, vx, vz, hd);
			else if (mode == 9)
				send_target(vx + off_x, vz, vx, vz, {hd[15:14], 14'd0});
			else
				send_target(vx + off_x, vz + off_z, vx, vz, hd);
			if (pause_often && i % 50 == 49) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				wait (pending_maps.size() == 0);
			end
		end
	endtask

	task automatic test_directed;
		logic [15:0] quads[6] = '{16'd0, 16'd8192, 16'd16384, 16'd32768, 16'd49152, 16'hFFFF};
		foreach (quads[i]) begin
			send_target(32'd16000, 32'd0, 32'd0, 32'd0, quads[i]);
			send_target(32'd3200, -32'sd4800, 32'd0, 32'd0, quads[i]);
		end
		send_target(32'd0, 32'd0, 32'd0, 32'd0, 16'h1234);
		send_target(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
		send_target(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h5555);
		send_target(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 16'hAAAA);
		send_target(32'd1, 32'd0, 32'd0, 32'd0, 16'd0);
		send_target(32'd8, 32'd8, 32'd0, 32'd0, 16'd0);
	endtask

	task automatic test_register_extremes;
		logic [15:0] sizes[6] = '{16'd16, 16'd1024, 16'd2047, 16'd10, 16'd0, 16'hF9FF};
		logic [15:0] ranges[4] = '{16'd0, 16'd1, 16'd65535, 16'd37};
		foreach (sizes[i]) begin
			write_reg(REG_DISPLAY_SIZE, sizes[i]);
			write_reg(REG_WORLD_RANGE, ranges[i % 4]);
			send_target(32'd100, -32'sd100, 32'd0, 32'd0, 16'd4000);
			send_target(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd0, 16'd0);
			send_random(30, 1'b0);
		end
		write_reg(REG_DISPLAY_SIZE, 16'd256);
		write_reg(REG_WORLD_RANGE, 16'd1000);
	endtask

	task automatic test_random_flow;
		int idle_mix[4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{17, 17}};
		foreach (idle_mix[i]) begin
			src_idle_pct = idle_mix[i][0];
			sink_stall_pct = idle_mix[i][1];
			send_random(250, 1'b0);
		end
	endtask

	task automatic test_drain_pause;
		src_idle_pct = 10;
		sink_stall_pct = 30;
		write_reg(REG_WORLD_RANGE, 16'd200);
		write_reg(REG_DISPLAY_SIZE, 16'd512);
		send_random(100, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = 1'b0;
		cfg_data = '0;
		disp_size = 11'd256;
		wrange = 16'd1000;
		mismatches = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_register_extremes();
		test_random_flow();
		test_drain_pause();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_maps.size() == 0);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_maps.size() == 0) begin
			$display("world_to_minimap_transform_top verification clean");
		end else begin
			$display("world_to_minimap_transform_top verification failed");
		end
		$finish;
	end

endmodule
